// ===== rtl/core/tep_pkg.sv =====
// ----------------------------------------------------------------------------
// tep_pkg
// Types and constants shared by the tree entry stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tep_pkg;

  // entry format limits
  localparam int HASH_BYTES         = 32;
  localparam int NAME_CAPACITY      = 256;
  localparam int MAX_ENTRIES        = 1024;
  localparam int MODE_TEXT_CAPACITY = 16;

  // field widths fixed by the state and result formats
  localparam int FIELD_W = 8;
  localparam int HPOS_W  = 6;
  localparam int COUNT_W = 11;
  localparam int MODE_W  = 32;

  // limits sized for the compares in the step logic
  localparam logic [FIELD_W:0]   NAME_LIMIT  = (FIELD_W + 1)'(NAME_CAPACITY);
  localparam logic [FIELD_W:0]   MODE_LIMIT  = (FIELD_W + 1)'(MODE_TEXT_CAPACITY);
  localparam logic [HPOS_W:0]    HASH_LIMIT  = (HPOS_W + 1)'(HASH_BYTES);
  localparam logic [COUNT_W-1:0] ENTRY_LIMIT = COUNT_W'(MAX_ENTRIES);

  // delimiter characters
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef enum logic [1:0] {
    PH_MODE = 2'd0,
    PH_NAME = 2'd1,
    PH_HASH = 2'd2
  } tep_phase_t;

  typedef enum logic [1:0] {
    KIND_MODE    = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_HASH    = 2'd2,
    KIND_IGNORED = 2'd3
  } tep_kind_t;

  typedef struct packed {
    tep_phase_t           phase;
    logic [MODE_W-1:0]    mode_acc;
    logic                 digits_stopped;
    logic [FIELD_W-1:0]   field_length;
    logic [HPOS_W-1:0]    hash_position;
    logic [COUNT_W-1:0]   entries;
    logic                 error;
  } tep_state_t;

  typedef struct packed {
    tep_kind_t            byte_kind;
    logic [7:0]           byte_value;
    logic [9:0]           entry_number;
    logic [FIELD_W-1:0]   name_position;
    logic [MODE_W-1:0]    entry_mode;
    logic                 entry_complete;
    logic                 buffer_done;
    logic                 format_error;
    logic [COUNT_W-1:0]   entry_total;
  } tep_result_t;

  localparam tep_state_t STATE_RESET = '{
    phase:          PH_MODE,
    mode_acc:       '0,
    digits_stopped: 1'b0,
    field_length:   '0,
    hash_position:  '0,
    entries:        '0,
    error:          1'b0
  };

endpackage

`default_nettype wire

// ===== rtl/core/tep_in_if.sv =====
// ----------------------------------------------------------------------------
// tep_in_if
// Byte stream channel into the parser: one buffer byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tep_out_if.sv =====
// ----------------------------------------------------------------------------
// tep_out_if
// Result channel out of the parser: one classified byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_kind;
  logic [7:0]  byte_value;
  logic [9:0]  entry_number;
  logic [7:0]  name_position;
  logic [31:0] entry_mode;
  logic        entry_complete;
  logic        buffer_done;
  logic        format_error;
  logic [10:0] entry_total;

  modport source (
    output valid, input ready,
    output byte_kind, output byte_value, output entry_number, output name_position,
    output entry_mode, output entry_complete, output buffer_done, output format_error,
    output entry_total
  );
  modport sink (
    input valid, output ready,
    input byte_kind, input byte_value, input entry_number, input name_position,
    input entry_mode, input entry_complete, input buffer_done, input format_error,
    input entry_total
  );
endinterface

`default_nettype wire

// ===== rtl/core/tep_step.sv =====
// ----------------------------------------------------------------------------
// tep_step
// Per-byte parse step: classifies one byte against the current parse state
// and produces the next state and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tep_step (
  input  tep_pkg::tep_state_t  state,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_buffer,
  output tep_pkg::tep_state_t  state_next,
  output tep_pkg::tep_result_t result
);
  import tep_pkg::*;

  tep_state_t         ns;
  tep_kind_t          kind;
  logic [9:0]         number;
  logic [FIELD_W-1:0] npos;
  logic [MODE_W-1:0]  mode;
  logic               complete;
  logic [FIELD_W:0]   fl_inc;
  logic [HPOS_W:0]    hp_inc;
  logic               is_octal;

  assign fl_inc   = {1'b0, state.field_length} + (FIELD_W + 1)'(1);
  assign hp_inc   = {1'b0, state.hash_position} + (HPOS_W + 1)'(1);
  assign is_octal = (data_byte[7:3] == 5'b00110);

  // phase update for one byte
  always_comb begin
    ns       = state;
    kind     = KIND_IGNORED;
    number   = '0;
    npos     = '0;
    mode     = '0;
    complete = 1'b0;

    if (!state.error && state.entries < ENTRY_LIMIT) begin
      number = state.entries[9:0];
      mode   = state.mode_acc;
      unique case (state.phase)
        PH_NAME: begin
          if (data_byte == CHAR_NUL) begin
            kind             = KIND_MODE;
            ns.phase         = PH_HASH;
            ns.hash_position = '0;
          end else begin
            kind = KIND_NAME;
            npos = state.field_length;
            if (fl_inc >= NAME_LIMIT) begin
              ns.error = 1'b1;
            end else begin
              ns.field_length = fl_inc[FIELD_W-1:0];
            end
          end
        end
        PH_HASH: begin
          kind = KIND_HASH;
          if (hp_inc >= HASH_LIMIT) begin
            complete          = 1'b1;
            npos              = state.field_length;
            ns.entries        = state.entries + COUNT_W'(1);
            ns.phase          = PH_MODE;
            ns.mode_acc       = '0;
            ns.digits_stopped = 1'b0;
            ns.field_length   = '0;
            ns.hash_position  = '0;
          end else begin
            ns.hash_position = hp_inc[HPOS_W-1:0];
          end
        end
        default: begin
          // mode text, also the unreachable fourth phase code
          kind = KIND_MODE;
          if (data_byte == CHAR_SPACE) begin
            ns.phase        = PH_NAME;
            ns.field_length = '0;
          end else begin
            if (!state.digits_stopped && is_octal) begin
              ns.mode_acc = {state.mode_acc[MODE_W-4:0], data_byte[2:0]};
            end else begin
              ns.digits_stopped = 1'b1;
            end
            if (fl_inc >= MODE_LIMIT) begin
              ns.error = 1'b1;
            end else begin
              ns.field_length = fl_inc[FIELD_W-1:0];
            end
          end
          mode = ns.mode_acc;
        end
      endcase
    end

    // buffer ending inside an entry
    if (end_of_buffer && !ns.error && (ns.phase != PH_MODE || ns.field_length != '0)) begin
      ns.error = 1'b1;
    end
  end

  // result beat, and next state (reset after the end of a buffer)
  always_comb begin
    result.byte_kind      = kind;
    result.byte_value     = data_byte;
    result.entry_number   = number;
    result.name_position  = npos;
    result.entry_mode     = mode;
    result.entry_complete = complete;
    result.buffer_done    = end_of_buffer;
    result.format_error   = ns.error;
    result.entry_total    = ns.entries;
    state_next            = end_of_buffer ? STATE_RESET : ns;
  end

endmodule

`default_nettype wire

// ===== rtl/core/tree_entry_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tree_entry_stream_parser
// Streaming parser for serialized tree entries: octal mode, name, hash.
// ----------------------------------------------------------------------------
// Takes one buffer byte per cycle and returns exactly one result beat per
// byte, in a result register in the cycle after the byte is taken. The parse
// state (phase, mode accumulator, field and hash counters, entry count and
// error flag) is a single register updated once per byte, so a byte can be
// taken every cycle; input ready drops only while the result register holds
// a beat that the consumer has not yet taken. All parse state returns to its
// reset value after a beat marked end of buffer, so the next byte starts a
// fresh buffer.
`default_nettype none

module tree_entry_stream_parser (
  input  logic       clk,
  input  logic       rst,
  tep_in_if.sink     in_stream,
  tep_out_if.source  out_stream
);
  import tep_pkg::*;

  tep_state_t  state;
  tep_state_t  state_next;
  tep_result_t step_result;
  tep_result_t res;
  logic        res_valid;
  logic        in_fire;
  logic        out_fire;

  assign in_stream.ready = !res_valid || out_stream.ready;
  assign in_fire         = in_stream.valid && in_stream.ready;
  assign out_fire        = res_valid && out_stream.ready;

  // per-byte parse logic
  tep_step u_step (
    .state         (state),
    .data_byte     (in_stream.data_byte),
    .end_of_buffer (in_stream.end_of_buffer),
    .state_next    (state_next),
    .result        (step_result)
  );

  // parse state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_fire) begin
      res_valid <= 1'b1;
    end else if (out_fire) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= step_result;
    end
  end

  // output beat
  assign out_stream.valid          = res_valid;
  assign out_stream.byte_kind      = res.byte_kind;
  assign out_stream.byte_value     = res.byte_value;
  assign out_stream.entry_number   = res.entry_number;
  assign out_stream.name_position  = res.name_position;
  assign out_stream.entry_mode     = res.entry_mode;
  assign out_stream.entry_complete = res.entry_complete;
  assign out_stream.buffer_done    = res.buffer_done;
  assign out_stream.format_error   = res.format_error;
  assign out_stream.entry_total    = res.entry_total;

  // checks
  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    state.entries <= ENTRY_LIMIT)
    else $error("entry count past limit");

  a_eob_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_stream.end_of_buffer |=>
      state.entries == '0 && !state.error && state.phase == PH_MODE &&
      state.field_length == '0)
    else $error("state not cleared after end of buffer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_stream.ready |-> !in_fire)
    else $error("pending result overwritten");

  a_complete_is_hash: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.entry_complete |-> res.byte_kind == KIND_HASH)
    else $error("entry completed on a non-hash byte");

  a_error_ignores: assert property (@(posedge clk) disable iff (rst)
    in_fire && state.error |=> res.byte_kind == KIND_IGNORED && res.format_error)
    else $error("byte parsed after latched error");

endmodule

`default_nettype wire
